// ----- sv/vrr_pkg.sv -----
// ----------------------------------------------------------------------------
// vrr_pkg: shared types and constants for the viewport resize relayout block
// Field widths, mode codes, third classes and the lane interface structs.
// ----------------------------------------------------------------------------
package vrr_pkg;

   // field widths
   localparam int POS_W   = 20;
   localparam int SIZE_W  = 19;
   localparam int VP_W    = 14;
   localparam int BAND_W  = 9;
   localparam int DVS_W   = 15;

   // divider: magnitude width equals the number of quotient stages
   localparam int DIV_N   = 40;
   localparam int QUO_W   = DIV_N + 1;

   // lane latency: five own stages plus two dividers
   localparam int LANE_LAT = 2 * DIV_N + 5;

   localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

   // size modes
   localparam logic [1:0] SIZE_KEEP   = 2'd0;
   localparam logic [1:0] SIZE_AXIS   = 2'd1;
   localparam logic [1:0] SIZE_HEIGHT = 2'd2;

   // place modes
   localparam logic [2:0] PLACE_KEEP   = 3'd0;
   localparam logic [2:0] PLACE_SCALE  = 3'd1;
   localparam logic [2:0] PLACE_THIRDS = 3'd2;
   localparam logic [2:0] PLACE_HEIGHT = 3'd3;
   localparam logic [2:0] PLACE_ABS    = 3'd4;

   // register indexes
   localparam logic [2:0] REG_OLD_W = 3'd0;
   localparam logic [2:0] REG_OLD_H = 3'd1;
   localparam logic [2:0] REG_NEW_W = 3'd2;
   localparam logic [2:0] REG_NEW_H = 3'd3;
   localparam logic [2:0] REG_BAND  = 3'd4;
   localparam logic [2:0] REG_SIZE  = 3'd5;
   localparam logic [2:0] REG_PLACE = 3'd6;

   // third classes
   localparam logic [1:0] CLS_LOW  = 2'd0;
   localparam logic [1:0] CLS_HIGH = 2'd1;
   localparam logic [1:0] CLS_MID  = 2'd2;

   // per-axis view of the configuration
   typedef struct packed {
      logic [VP_W-1:0]   o;      // own old size, never zero
      logic [VP_W-1:0]   n;      // own new size
      logic [VP_W-1:0]   ro;     // height ratio divisor
      logic [VP_W-1:0]   rn;     // height ratio multiplier
      logic [VP_W-1:0]   sz_o;   // size ratio divisor
      logic [VP_W-1:0]   sz_n;   // size ratio multiplier
      logic [2:0]        place;
      logic [BAND_W-1:0] band;
   } lane_cfg_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos;
      logic [SIZE_W-1:0]       size;
   } lane_res_type;

endpackage

// ----- sv/vrr_div.sv -----
// ----------------------------------------------------------------------------
// vrr_div: pipelined restoring divider
// One quotient bit per stage, truncating toward zero via sign-magnitude.
// ----------------------------------------------------------------------------
module vrr_div (
   input  logic                                clock,
   input  logic                                adv,
   input  logic [vrr_pkg::DIV_N-1:0]           mag_in,
   input  logic                                neg_in,
   input  logic [vrr_pkg::DVS_W-1:0]           dvs_in,
   output logic signed [vrr_pkg::QUO_W-1:0]    quo_out
);

   localparam int N = vrr_pkg::DIV_N;
   localparam int D = vrr_pkg::DVS_W;

   logic [N-1:0] nq_ff  [N];
   logic [N-1:0] nq_in  [N];
   logic [D-1:0] rem_ff [N];
   logic [D-1:0] rem_in [N];
   logic [D-1:0] dvs_ff [N];
   logic [D-1:0] dvs_in_s [N];
   logic         neg_ff [N];
   logic         neg_in_s [N];

   // one compare-subtract per stage
   always_comb begin
      logic [N-1:0] nq_src;
      logic [D-1:0] rem_src;
      logic [D-1:0] dvs_src;
      logic         neg_src;
      logic [D:0]   trial;
      logic         ge;
      for (int k = 0; k < N; k++) begin
         if (k == 0) begin
            nq_src  = mag_in;
            rem_src = '0;
            dvs_src = dvs_in;
            neg_src = neg_in;
         end else begin
            nq_src  = nq_ff[k-1];
            rem_src = rem_ff[k-1];
            dvs_src = dvs_ff[k-1];
            neg_src = neg_ff[k-1];
         end
         trial = {rem_src, nq_src[N-1]};
         ge    = (trial >= {1'b0, dvs_src});
         if (ge) begin
            rem_in[k] = D'(trial - {1'b0, dvs_src});
         end else begin
            rem_in[k] = trial[D-1:0];
         end
         nq_in[k]    = {nq_src[N-2:0], ge};
         dvs_in_s[k] = dvs_src;
         neg_in_s[k] = neg_src;
      end
   end

   // advance the stages together
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < N; k++) begin
            nq_ff[k]  <= nq_in[k];
            rem_ff[k] <= rem_in[k];
            dvs_ff[k] <= dvs_in_s[k];
            neg_ff[k] <= neg_in_s[k];
         end
      end
   end

   // restore the sign
   assign quo_out = neg_ff[N-1] ? -$signed({1'b0, nq_ff[N-1]})
                                :  $signed({1'b0, nq_ff[N-1]});

endmodule

// ----- sv/vrr_lane.sv -----
// ----------------------------------------------------------------------------
// vrr_lane: relayout of one axis
// Size division, then choice of position formula and position division.
// ----------------------------------------------------------------------------
module vrr_lane (
   input  logic                            clock,
   input  logic                            adv,
   input  vrr_pkg::lane_cfg_type           cfg,
   input  logic signed [vrr_pkg::POS_W-1:0] p_in,
   input  logic [vrr_pkg::SIZE_W-1:0]      s_in,
   output vrr_pkg::lane_res_type           res_out
);

   localparam int N  = vrr_pkg::DIV_N;
   localparam int PW = vrr_pkg::POS_W;
   localparam int SW = vrr_pkg::SIZE_W;
   localparam int VW = vrr_pkg::VP_W;
   localparam int DW = vrr_pkg::DVS_W;

   typedef struct packed {
      logic signed [PW-1:0] p;
      logic [SW-1:0]        s;
      logic [1:0]           cls;
      logic                 ml;
      logic                 mr;
   } geo_type;

   typedef struct packed {
      logic [17:0] base;
      logic        negq;
      logic        subsn;
      logic [SW-1:0] sn;
   } fix_type;

   // ---------------- stage A: classify, size product
   logic signed [21:0] m2_a;
   logic signed [10:0] band_lo;
   logic signed [10:0] band_hi;
   logic signed [26:0] thr_lo;
   logic signed [26:0] thr_hi;
   logic signed [26:0] m16_a;
   logic signed [21:0] w16_a;
   geo_type            geo_a;
   geo_type            geo_ff;
   logic [32:0]        szp_ff;

   always_comb begin
      m2_a    = $signed({p_in[PW-1], p_in, 1'b0}) + $signed({3'b000, s_in});
      band_lo = 11'sd256 - $signed({2'b00, cfg.band});
      band_hi = 11'sd256 + $signed({2'b00, cfg.band});
      thr_lo  = $signed({1'b0, cfg.o}) * band_lo;
      thr_hi  = $signed({1'b0, cfg.o}) * band_hi;
      m16_a   = $signed({m2_a[21], m2_a, 4'b0000});
      w16_a   = $signed({4'b0000, cfg.o, 4'b0000});
      geo_a.p = p_in;
      geo_a.s = s_in;
      if (m16_a < thr_lo) begin
         geo_a.cls = vrr_pkg::CLS_LOW;
      end else if (m16_a > thr_hi) begin
         geo_a.cls = vrr_pkg::CLS_HIGH;
      end else begin
         geo_a.cls = vrr_pkg::CLS_MID;
      end
      geo_a.ml = (m2_a < (w16_a - 22'sd32));
      geo_a.mr = (m2_a > (w16_a + 22'sd32));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         geo_ff <= geo_a;
         szp_ff <= s_in * cfg.sz_n;
      end
   end

   // ---------------- size division
   logic signed [vrr_pkg::QUO_W-1:0] q1;
   geo_type dl1_ff [N];

   vrr_div u_div_size (
      .clock   (clock),
      .adv     (adv),
      .mag_in  ({7'b0, szp_ff}),
      .neg_in  (1'b0),
      .dvs_in  ({1'b0, cfg.sz_o}),
      .quo_out (q1)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         dl1_ff[0] <= geo_ff;
         for (int k = 1; k < N; k++) begin
            dl1_ff[k] <= dl1_ff[k-1];
         end
      end
   end

   // ---------------- stage B: saturate size
   geo_type       geo_b_ff;
   logic [SW-1:0] sn_b_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         geo_b_ff <= dl1_ff[N-1];
         if (q1 > $signed({{(vrr_pkg::QUO_W-SW){1'b0}}, vrr_pkg::SIZE_MAX})) begin
            sn_b_ff <= vrr_pkg::SIZE_MAX;
         end else begin
            sn_b_ff <= q1[SW-1:0];
         end
      end
   end

   // ---------------- stage C: pick formula, multiply
   logic signed [22:0] ps_c;
   logic signed [22:0] m2_c;
   logic signed [22:0] w16_c;
   logic signed [22:0] w8_c;
   logic signed [22:0] a_c;
   logic [VW-1:0]      mn_c;
   logic [DW-1:0]      dvs_c;
   logic               sno_c;
   fix_type            fix_c;
   logic signed [38:0] prod1_ff;
   logic [32:0]        prod2_ff;
   logic               sno_ff;
   logic [DW-1:0]      dvs_ff;
   fix_type            fix_ff;

   always_comb begin
      ps_c  = $signed({{3{geo_b_ff.p[PW-1]}}, geo_b_ff.p}) + $signed({4'b0000, geo_b_ff.s});
      m2_c  = ps_c + $signed({{3{geo_b_ff.p[PW-1]}}, geo_b_ff.p});
      w16_c = $signed({5'b00000, cfg.o, 4'b0000});
      w8_c  = $signed({6'b000000, cfg.o, 3'b000});
      a_c         = $signed({{3{geo_b_ff.p[PW-1]}}, geo_b_ff.p});
      mn_c        = VW'(1);
      dvs_c       = DW'(1);
      sno_c       = 1'b0;
      fix_c.base  = '0;
      fix_c.negq  = 1'b0;
      fix_c.subsn = 1'b0;
      fix_c.sn    = sn_b_ff;
      case (cfg.place)
         vrr_pkg::PLACE_SCALE: begin
            mn_c  = cfg.n;
            dvs_c = {1'b0, cfg.o};
         end
         vrr_pkg::PLACE_THIRDS: begin
            mn_c  = cfg.n;
            dvs_c = {1'b0, cfg.o};
            if (geo_b_ff.cls == vrr_pkg::CLS_HIGH) begin
               a_c         = ps_c;
               fix_c.subsn = 1'b1;
            end else if (geo_b_ff.cls == vrr_pkg::CLS_MID) begin
               a_c   = m2_c;
               sno_c = 1'b1;
               dvs_c = {cfg.o, 1'b0};
            end
         end
         vrr_pkg::PLACE_HEIGHT: begin
            mn_c  = cfg.rn;
            dvs_c = {1'b0, cfg.ro};
            if (geo_b_ff.cls == vrr_pkg::CLS_HIGH) begin
               a_c         = w16_c - ps_c;
               fix_c.base  = {cfg.n, 4'b0000};
               fix_c.negq  = 1'b1;
               fix_c.subsn = 1'b1;
            end else if (geo_b_ff.cls == vrr_pkg::CLS_MID) begin
               if (geo_b_ff.ml) begin
                  a_c         = ps_c - w8_c;
                  fix_c.base  = {1'b0, cfg.n, 3'b000};
                  fix_c.subsn = 1'b1;
               end else if (geo_b_ff.mr) begin
                  a_c        = a_c - w8_c;
                  fix_c.base = {1'b0, cfg.n, 3'b000};
               end else begin
                  // centre band: width-ratio middle formula
                  a_c   = m2_c;
                  mn_c  = cfg.n;
                  sno_c = 1'b1;
                  dvs_c = {cfg.o, 1'b0};
               end
            end
         end
         vrr_pkg::PLACE_ABS: begin
            if (geo_b_ff.cls == vrr_pkg::CLS_HIGH) begin
               a_c         = ps_c;
               fix_c.base  = {cfg.n, 4'b0000};
               fix_c.negq  = 1'b1;
               fix_c.subsn = 1'b1;
            end else if (geo_b_ff.cls == vrr_pkg::CLS_MID) begin
               a_c   = m2_c;
               mn_c  = cfg.n;
               sno_c = 1'b1;
               dvs_c = {cfg.o, 1'b0};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod1_ff <= a_c * $signed({1'b0, mn_c});
         prod2_ff <= sn_b_ff * cfg.o;
         sno_ff   <= sno_c;
         dvs_ff   <= dvs_c;
         fix_ff   <= fix_c;
      end
   end

   // ---------------- stage D: numerator to sign-magnitude
   logic signed [N-1:0] num_d;
   logic [N-1:0]        mag_ff;
   logic                neg_ff;
   logic [DW-1:0]       dvs_d_ff;
   fix_type             fix_d_ff;

   always_comb begin
      num_d = $signed({prod1_ff[38], prod1_ff});
      if (sno_ff) begin
         num_d = num_d - $signed({7'b0, prod2_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         neg_ff   <= num_d[N-1];
         mag_ff   <= num_d[N-1] ? N'(-num_d) : N'(num_d);
         dvs_d_ff <= dvs_ff;
         fix_d_ff <= fix_ff;
      end
   end

   // ---------------- position division
   logic signed [vrr_pkg::QUO_W-1:0] q2;
   fix_type dl2_ff [N];

   vrr_div u_div_pos (
      .clock   (clock),
      .adv     (adv),
      .mag_in  (mag_ff),
      .neg_in  (neg_ff),
      .dvs_in  (dvs_d_ff),
      .quo_out (q2)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         dl2_ff[0] <= fix_d_ff;
         for (int k = 1; k < N; k++) begin
            dl2_ff[k] <= dl2_ff[k-1];
         end
      end
   end

   // ---------------- stage E: offset, subtract size, saturate
   fix_type            fix_e;
   logic signed [43:0] sum_e;
   vrr_pkg::lane_res_type res_ff;

   always_comb begin
      fix_e = dl2_ff[N-1];
      sum_e = $signed({26'b0, fix_e.base});
      if (fix_e.negq) begin
         sum_e = sum_e - 44'(q2);
      end else begin
         sum_e = sum_e + 44'(q2);
      end
      if (fix_e.subsn) begin
         sum_e = sum_e - $signed({25'b0, fix_e.sn});
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff.size <= fix_e.sn;
         if (sum_e > 44'sd524287) begin
            res_ff.pos <= 20'sh7FFFF;
         end else if (sum_e < -44'sd524288) begin
            res_ff.pos <= 20'sh80000;
         end else begin
            res_ff.pos <= sum_e[PW-1:0];
         end
      end
   end

   assign res_out = res_ff;

endmodule

// ----- sv/viewport_resize_relayout_top.sv -----
// ----------------------------------------------------------------------------
// viewport_resize_relayout_top: rectangle relayout after a viewport resize
// Two axis lanes compute size and position; the result stage merges them.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req_      in         req_tvalid/req_tready  tdata: pos_x, pos_y, width_in, height_in
//  rsp_      out        rsp_tvalid/rsp_tready  tdata: new_pos_x, new_pos_y, sizes
//  csr_      in         csr_valid/csr_ready    csr_index, csr_wdata
//
//  One request per cycle is accepted while no stalled result holds the pipeline;
//  each result passes through the two 40-stage pipelined dividers in each lane.
//  Synchronous active-high reset clears the valid flags and presets the configuration.
//  A stalled result holds the pipeline only when its last stage is occupied.
// ----------------------------------------------------------------------------
module viewport_resize_relayout_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // pos_x[19:0], pos_y[39:20], width_in[58:40],
                                    // height_in[77:59], zero[79:78]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // new_pos_x[19:0], new_pos_y[39:20],
                                    // new_width_out[58:40], new_height_out[77:59]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [13:0] csr_wdata
);

   localparam int LAT = vrr_pkg::LANE_LAT;
   localparam int VW  = vrr_pkg::VP_W;

   // ---------------- configuration registers
   logic [VW-1:0] old_w_ff, old_h_ff, new_w_ff, new_h_ff;
   logic [vrr_pkg::BAND_W-1:0] band_ff;
   logic [1:0] size_mode_ff;
   logic [2:0] place_mode_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         old_w_ff      <= VW'(1);
         old_h_ff      <= VW'(1);
         new_w_ff      <= '0;
         new_h_ff      <= '0;
         band_ff       <= 9'd128;
         size_mode_ff  <= vrr_pkg::SIZE_HEIGHT;
         place_mode_ff <= vrr_pkg::PLACE_HEIGHT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            vrr_pkg::REG_OLD_W: old_w_ff      <= csr_wdata;
            vrr_pkg::REG_OLD_H: old_h_ff      <= csr_wdata;
            vrr_pkg::REG_NEW_W: new_w_ff      <= csr_wdata;
            vrr_pkg::REG_NEW_H: new_h_ff      <= csr_wdata;
            vrr_pkg::REG_BAND:  band_ff       <= csr_wdata[8:0];
            vrr_pkg::REG_SIZE:  size_mode_ff  <= csr_wdata[1:0];
            vrr_pkg::REG_PLACE: place_mode_ff <= csr_wdata[2:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------- per-lane configuration views
   logic [VW-1:0] ow, oh;
   vrr_pkg::lane_cfg_type cfg_x, cfg_y;

   always_comb begin
      ow = (old_w_ff == '0) ? VW'(1) : old_w_ff;
      oh = (old_h_ff == '0) ? VW'(1) : old_h_ff;

      cfg_x.o     = ow;
      cfg_x.n     = new_w_ff;
      cfg_x.ro    = oh;
      cfg_x.rn    = new_h_ff;
      cfg_x.place = place_mode_ff;
      cfg_x.band  = band_ff;
      cfg_y.o     = oh;
      cfg_y.n     = new_h_ff;
      cfg_y.ro    = oh;
      cfg_y.rn    = new_h_ff;
      cfg_y.band  = band_ff;
      // y follows the plain thirds rule in the height mode
      cfg_y.place = (place_mode_ff == vrr_pkg::PLACE_HEIGHT) ? vrr_pkg::PLACE_THIRDS
                                                             : place_mode_ff;
      case (size_mode_ff)
         vrr_pkg::SIZE_AXIS: begin
            cfg_x.sz_o = ow;
            cfg_x.sz_n = new_w_ff;
            cfg_y.sz_o = oh;
            cfg_y.sz_n = new_h_ff;
         end
         vrr_pkg::SIZE_HEIGHT: begin
            cfg_x.sz_o = oh;
            cfg_x.sz_n = new_h_ff;
            cfg_y.sz_o = oh;
            cfg_y.sz_n = new_h_ff;
         end
         default: begin
            cfg_x.sz_o = VW'(1);
            cfg_x.sz_n = VW'(1);
            cfg_y.sz_o = VW'(1);
            cfg_y.sz_n = VW'(1);
         end
      endcase
   end

   // ---------------- pipeline control
   logic [LAT-1:0] vld_ff;
   logic           rsp_valid_ff;
   logic           adv;

   assign adv        = rsp_tready || !rsp_valid_ff || !vld_ff[LAT-1];
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   // ---------------- lanes
   vrr_pkg::lane_res_type res_x, res_y;

   vrr_lane u_lane_x (
      .clock   (clock),
      .adv     (adv),
      .cfg     (cfg_x),
      .p_in    ($signed(req_tdata[19:0])),
      .s_in    (req_tdata[58:40]),
      .res_out (res_x)
   );

   vrr_lane u_lane_y (
      .clock   (clock),
      .adv     (adv),
      .cfg     (cfg_y),
      .p_in    ($signed(req_tdata[39:20])),
      .s_in    (req_tdata[77:59]),
      .res_out (res_y)
   );

   // ---------------- merge into the output register
   logic [79:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv && vld_ff[LAT-1]) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && vld_ff[LAT-1]) begin
         rsp_data_ff <= {2'b00, res_y.size, res_x.size, res_y.pos, res_x.pos};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- assertions
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready && vld_ff[LAT-1]) |-> !req_tready)
      else $error("request taken while a finished result is blocked");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vld_ff[0])
      else $error("accepted request did not enter the pipeline");

   a_deliver: assert property (@(posedge clock) disable iff (reset)
      (adv && vld_ff[LAT-1]) |=> rsp_valid_ff)
      else $error("finished result was not presented");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the viewport resize relayout block
// Writes viewport and mode registers between phases, streams rectangles with
// random gaps and back-pressure, predicts each relayout and compares fields.
// ----------------------------------------------------------------------------
module tb_top;

   // packed from the top bit down, so pos_x lands in the lowest bits
   typedef struct packed {
      logic [18:0]        sy;
      logic [18:0]        sx;
      logic signed [19:0] py;
      logic signed [19:0] px;
   } rect_type;

   typedef struct {
      logic [2:0]  idx;
      logic [13:0] val;
   } csr_wr_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [13:0] csr_wdata = '0;

   viewport_resize_relayout_top u_top (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor copy of the registers
   longint m_ow = 1, m_oh = 1, m_nw = 0, m_nh = 0, m_band = 128;
   longint m_size = 2, m_place = 3;

   rect_type   pending_rects[$];
   rect_type   expected_rects[$];
   csr_wr_type pending_writes[$];
   int      errors = 0;
   int      checked = 0;
   int      accepted = 0;
   bit      stim_done = 0;
   bit      stall_hold = 0;

   function automatic longint sat(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint nz(longint v);
      return v == 0 ? 1 : v;
   endfunction

   // 0 low, 1 high, 2 middle
   function automatic int third_of(longint m2, longint o);
      if (16 * m2 < o * (256 - m_band)) return 0;
      if (16 * m2 > o * (256 + m_band)) return 1;
      return 2;
   endfunction

   function automatic longint mid_pos(longint m2, longint sn, longint o, longint n);
      return (m2 * n - sn * o) / (2 * o);
   endfunction

   function automatic longint thirds_pos(longint p, longint s, longint sn,
                                         longint o, longint n, bit absolute);
      longint m2;
      m2 = 2 * p + s;
      case (third_of(m2, o))
         0: return absolute ? p : p * n / o;
         1: return absolute ? 16 * n - (p + s) - sn : (p + s) * n / o - sn;
         default: return mid_pos(m2, sn, o, n);
      endcase
   endfunction

   function automatic longint height_pos_x(longint p, longint s, longint sn,
                                           longint ow, longint oh);
      longint m2, w16;
      m2 = 2 * p + s;
      w16 = 16 * ow;
      case (third_of(m2, ow))
         0: return p * m_nh / oh;
         1: return 16 * m_nw - (w16 - (p + s)) * m_nh / oh - sn;
         default: begin
            if (m2 < w16 - 32) return 8 * m_nw + (p + s - 8 * ow) * m_nh / oh - sn;
            if (m2 > w16 + 32) return 8 * m_nw + (p - 8 * ow) * m_nh / oh;
            return mid_pos(m2, sn, ow, m_nw);
         end
      endcase
   endfunction

   function automatic rect_type relayout(rect_type r);
      longint px, py, sx, sy, ow, oh, wx, wy, qx, qy;
      rect_type o;
      px = r.px; py = r.py; sx = r.sx; sy = r.sy;
      ow = nz(m_ow); oh = nz(m_oh);
      wx = sx; wy = sy; qx = px; qy = py;
      if (m_size == vrr_pkg::SIZE_AXIS) begin
         wx = sx * m_nw / ow;
         wy = sy * m_nh / oh;
      end else if (m_size == vrr_pkg::SIZE_HEIGHT) begin
         wx = sx * m_nh / oh;
         wy = sy * m_nh / oh;
      end
      wx = sat(wx, 0, 524287);
      wy = sat(wy, 0, 524287);
      case (m_place)
         vrr_pkg::PLACE_SCALE: begin
            qx = px * m_nw / ow;
            qy = py * m_nh / oh;
         end
         vrr_pkg::PLACE_THIRDS: begin
            qx = thirds_pos(px, sx, wx, ow, m_nw, 0);
            qy = thirds_pos(py, sy, wy, oh, m_nh, 0);
         end
         vrr_pkg::PLACE_HEIGHT: begin
            qx = height_pos_x(px, sx, wx, ow, oh);
            qy = thirds_pos(py, sy, wy, oh, m_nh, 0);
         end
         vrr_pkg::PLACE_ABS: begin
            qx = thirds_pos(px, sx, wx, ow, m_nw, 1);
            qy = thirds_pos(py, sy, wy, oh, m_nh, 1);
         end
         default: ;
      endcase
      o.px = 20'(sat(qx, -524288, 524287));
      o.py = 20'(sat(qy, -524288, 524287));
      o.sx = 19'(wx);
      o.sy = 19'(wy);
      return o;
   endfunction

   function automatic void apply_reg(logic [2:0] idx, longint v);
      case (idx)
         vrr_pkg::REG_OLD_W: m_ow = v;
         vrr_pkg::REG_OLD_H: m_oh = v;
         vrr_pkg::REG_NEW_W: m_nw = v;
         vrr_pkg::REG_NEW_H: m_nh = v;
         vrr_pkg::REG_BAND:  m_band = v & 9'h1ff;
         vrr_pkg::REG_SIZE:  m_size = v & 2'h3;
         vrr_pkg::REG_PLACE: m_place = v & 3'h7;
         default: ;
      endcase
   endfunction

   // request driver: random gap before each rectangle
   int req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_rects.push_back(relayout(rect_type'(req_tdata[77:0])));
            accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_rects.size() > 0) begin
               req_tdata  <= {2'b00, pending_rects.pop_front()};
               req_tvalid <= 1'b1;
               req_gap    <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // register write driver
   always @(posedge clock) begin
      if (reset) begin
         csr_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) apply_reg(csr_index, csr_wdata);
         if (!csr_valid || csr_ready) begin
            if (pending_writes.size() > 0) begin
               csr_index <= pending_writes[0].idx;
               csr_wdata <= pending_writes[0].val;
               csr_valid <= 1'b1;
               void'(pending_writes.pop_front());
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor with random back-pressure and one long hold-off
   int rsp_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rects.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_tdata);
               errors++;
            end else begin
               rect_type e, a;
               e = expected_rects.pop_front();
               a = rect_type'(rsp_tdata[77:0]);
               if (a.px !== e.px) begin
                  $display("%0t: new_pos_x exp %0d got %0d", $time, e.px, a.px);
                  errors++;
               end
               if (a.py !== e.py) begin
                  $display("%0t: new_pos_y exp %0d got %0d", $time, e.py, a.py);
                  errors++;
               end
               if (a.sx !== e.sx) begin
                  $display("%0t: new_width exp %0d got %0d", $time, e.sx, a.sx);
                  errors++;
               end
               if (a.sy !== e.sy) begin
                  $display("%0t: new_height exp %0d got %0d", $time, e.sy, a.sy);
                  errors++;
               end
            end
            checked++;
         end
         if (stall_hold) begin
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_tvalid) rsp_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
         end
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [13:0] v);
      csr_wr_type w;
      w.idx = idx;
      w.val = v;
      pending_writes.push_back(w);
   endtask

   task automatic wait_idle();
      while (pending_rects.size() > 0 || req_tvalid || expected_rects.size() > 0 ||
             pending_writes.size() > 0 || csr_valid)
         @(posedge clock);
      repeat (vrr_pkg::LANE_LAT + 10) @(posedge clock);
   endtask

   function automatic rect_type rand_rect(longint ow, longint oh);
      rect_type r;
      int k;
      k = $urandom_range(0, 9);
      if (k < 2) begin
         r = rect_type'(78'({$urandom, $urandom, $urandom}));
      end else begin
         // mostly on-screen rectangles so every third is reached
         r.sx = 19'($urandom_range(0, 16 * ow));
         r.sy = 19'($urandom_range(0, 16 * oh));
         r.px = 20'($signed($urandom_range(0, 20 * ow)) - 2 * ow);
         r.py = 20'($signed($urandom_range(0, 20 * oh)) - 2 * oh);
         if (k == 2) r.px = 20'(8 * ow - r.sx / 2 + $signed($urandom_range(0, 40)) - 20);
      end
      return r;
   endfunction

   task automatic phase(int n, logic [13:0] ow, logic [13:0] oh, logic [13:0] nw,
                        logic [13:0] nh, logic [13:0] band, logic [13:0] sm,
                        logic [13:0] pm);
      write_reg(vrr_pkg::REG_OLD_W, ow);
      write_reg(vrr_pkg::REG_OLD_H, oh);
      write_reg(vrr_pkg::REG_NEW_W, nw);
      write_reg(vrr_pkg::REG_NEW_H, nh);
      write_reg(vrr_pkg::REG_BAND, band);
      write_reg(vrr_pkg::REG_SIZE, sm);
      write_reg(vrr_pkg::REG_PLACE, pm);
      while (pending_writes.size() > 0 || csr_valid) @(posedge clock);
      repeat (n) pending_rects.push_back(rand_rect(ow == 0 ? 1 : ow, oh == 0 ? 1 : oh));
      wait_idle();
   endtask

   initial begin
      rect_type r;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, field extremes
      r = '{px: 20'sh80000, py: 20'sh7ffff, sx: 19'h7ffff, sy: 19'h7ffff};
      pending_rects.push_back(r);
      r = '{px: 20'sh7ffff, py: 20'sh80000, sx: 19'h0, sy: 19'h0};
      pending_rects.push_back(r);
      r = '{px: 20'sh0, py: 20'sh0, sx: 19'h10, sy: 19'h10};
      pending_rects.push_back(r);
      wait_idle();
      // zero old dimension, band above one, unused modes, extremes of sizes
      phase(4, 0, 0, 16383, 16383, 511, 3, 7);
      phase(4, 16383, 16383, 0, 0, 0, 0, 5);
      phase(4, 1, 1, 16383, 16383, 256, 1, 1);
      phase(4, 100, 80, 200, 40, 128, 2, 3);

      // long receiver hold-off so the pipeline fills and stalls the input
      fork
         begin
            stall_hold = 1'b1;
            repeat (1000) @(posedge clock);
            stall_hold = 1'b0;
         end
      join_none
      phase(200, 640, 480, 1280, 720, 85, 1, 2);

      // randomized phases over every mode
      for (int i = 0; i < 14; i++) begin
         phase(50, 14'($urandom_range(1, 2000)), 14'($urandom_range(1, 2000)),
               14'($urandom_range(0, 4000)), 14'($urandom_range(0, 4000)),
               14'($urandom_range(0, 300)), 14'($urandom_range(0, 3)),
               14'($urandom_range(0, 7)));
      end
      phase(40, 16383, 1, 1, 16383, 0, 1, 4);
      stim_done = 1;
   end

   // final report
   initial begin
      wait (stim_done);
      $display("Covered %0d rectangles over all size and place modes, %0d results checked",
               accepted, checked);
      if (errors == 0 && expected_rects.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
